/* hdl/cooperative_task_timer_table_core_defines.svh */
// ----------------------------------------------------------------------------
// Cooperative task timer table - assertion macros
// Shared property shorthands for the checker of the timer table core.
// ----------------------------------------------------------------------------
`ifndef COOPERATIVE_TASK_TIMER_TABLE_CORE_DEFINES_SVH
`define COOPERATIVE_TASK_TIMER_TABLE_CORE_DEFINES_SVH

// Require cons in the same cycle as ante, outside reset.
`define CTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Require cons in the cycle after ante, outside reset.
`define CTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Require cons with ante, also while reset is applied.
`define CTT_ASSERT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, codes and payload types shared by the timer table modules.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // Table geometry
  localparam int SLOTS        = 8;
  localparam int PENDING_BITS = 8;
  localparam int MAX_OUT      = 8;
  localparam int CMD_DEPTH    = 2;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W        = $clog2(MAX_OUT + 1);
  localparam int CD_W         = 17;
  localparam int PTR_W        = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int FILL_W       = $clog2(CMD_DEPTH + 1);

  localparam logic [15:0] TICK_STEP_RST = 16'd50;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_DISP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TASK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Input item
  typedef struct packed {
    action_e     action;
    logic [7:0]  task_id;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [2:0]  slot;
  } req_t;

  // Result item
  typedef struct packed {
    kind_e      kind;
    logic [2:0] slot_index;
    logic [7:0] run_task;
    logic       ok;
    logic       last;
  } rsp_t;

  // Decoded command between front and back
  typedef struct packed {
    action_e             op;
    logic [7:0]          task_id;
    logic [CD_W-1:0]     init_cd;
    logic [15:0]         period;
    logic [2:0]          slot_field;
    logic [SLOT_W-1:0]   slot_idx;
    logic                slot_ok;
  } cmd_t;

  // One table entry
  typedef struct packed {
    logic [7:0]              task_id;
    logic [CD_W-1:0]         cd;
    logic [15:0]             period;
    logic [PENDING_BITS-1:0] pend;
  } slot_t;

endpackage

/* hdl/ctt_req_if.sv */
// ----------------------------------------------------------------------------
// Timer table request channel
// Valid/ready channel that carries one input item per transfer.
// ----------------------------------------------------------------------------
interface ctt_req_if;
  logic          valid;
  logic          ready;
  ctt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ctt_rsp_if.sv */
// ----------------------------------------------------------------------------
// Timer table result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface ctt_rsp_if;
  logic          valid;
  logic          ready;
  ctt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ctt_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Timer table command queue
// Short queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module ctt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ctt_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ctt_pkg::cmd_t pop_cmd_o
);
  import ctt_pkg::*;

  cmd_t              mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != FILL_W'(CMD_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store pushed command
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/ctt_front.sv */
// ----------------------------------------------------------------------------
// Timer table front end
// Accepts input items, decodes them into commands and hands them to the queue.
// ----------------------------------------------------------------------------
module ctt_front (
  ctt_req_if.sink       req_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output ctt_pkg::cmd_t push_cmd_o
);
  import ctt_pkg::*;

  // Transfer straight into the queue whenever it has room
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

  // Decode: first countdown, slot range check
  always_comb begin
    push_cmd_o            = '0;
    push_cmd_o.op         = req_i.data.action;
    push_cmd_o.task_id    = req_i.data.task_id;
    push_cmd_o.init_cd    = {1'b0, req_i.data.start_delay} + CD_W'(1);
    push_cmd_o.period     = req_i.data.repeat_period;
    push_cmd_o.slot_field = req_i.data.slot;
    push_cmd_o.slot_idx   = SLOT_W'(req_i.data.slot);
    push_cmd_o.slot_ok    = (int'(req_i.data.slot) < SLOTS);
  end

endmodule

/* hdl/ctt_back.sv */
// ----------------------------------------------------------------------------
// Timer table back end
// Holds the slot table and executes commands, scanning one slot per cycle unless a dispatch waits on the output.
// ----------------------------------------------------------------------------
module ctt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ctt_pkg::cmd_t cmd_i,
  ctt_rsp_if.source     rsp_o
);
  import ctt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_DISP  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              hold_v_q, hold_v_d;
  logic [SLOT_W-1:0] hold_idx_q, hold_idx_d;
  logic [7:0]        hold_task_q, hold_task_d;
  logic [15:0]       tick_step_q;
  logic [SLOTS-1:0]  valid_q;
  slot_t             slot_q [SLOTS];
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              out_free;
  logic              out_load;
  slot_t             cur;
  logic              last_idx;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [CD_W-1:0]   cd_dec;
  logic [PENDING_BITS-1:0] pend_inc;
  logic              disp_rdy;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wa;
  slot_t             slot_wd;
  logic              valid_we;
  logic [SLOT_W-1:0] valid_wa;
  logic              valid_wd;

  function automatic rsp_t mk_rsp(kind_e kind, logic [2:0] idx, logic [7:0] tsk,
                                  logic ok, logic last);
    rsp_t r;
    r.kind       = kind;
    r.slot_index = idx;
    r.run_task   = tsk;
    r.ok         = ok;
    r.last       = last;
    return r;
  endfunction

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;
  assign cur         = slot_q[idx_q];
  assign last_idx    = (idx_q == SLOT_W'(SLOTS - 1));

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Countdown step for the scanned slot, floored at zero
  assign cd_dec   = (cur.cd > {1'b0, tick_step_q}) ? cur.cd - {1'b0, tick_step_q} : '0;
  assign pend_inc = (cur.pend == '1) ? cur.pend : cur.pend + PENDING_BITS'(1);
  assign disp_rdy = valid_q[idx_q] && (cur.pend != '0);

  // Sequence commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hold_v_d    = hold_v_q;
    hold_idx_d  = hold_idx_q;
    hold_task_d = hold_task_q;
    out_load    = 1'b0;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    slot_we     = 1'b0;
    slot_wa     = idx_q;
    slot_wd     = cur;
    valid_we    = 1'b0;
    valid_wa    = idx_q;
    valid_wd    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            ACT_TICK: begin
              cmd_ready_o = 1'b1;
              idx_d       = '0;
              state_d     = ST_TICK;
            end
            ACT_DISP: begin
              cmd_ready_o = 1'b1;
              idx_d       = '0;
              cnt_d       = '0;
              hold_v_d    = 1'b0;
              state_d     = ST_DISP;
            end
            ACT_ADD: begin
              if (out_free) begin
                cmd_ready_o = 1'b1;
                out_load    = 1'b1;
                if (free_found) begin
                  slot_we        = 1'b1;
                  slot_wa        = free_idx;
                  slot_wd.task_id = cmd_i.task_id;
                  slot_wd.cd     = cmd_i.init_cd;
                  slot_wd.period = cmd_i.period;
                  slot_wd.pend   = '0;
                  valid_we       = 1'b1;
                  valid_wa       = free_idx;
                  valid_wd       = 1'b1;
                  out_d = mk_rsp(KIND_ADD, 3'(free_idx), 8'd0, 1'b1, 1'b1);
                end else begin
                  out_d = mk_rsp(KIND_ADD, 3'd0, 8'd0, 1'b0, 1'b1);
                end
              end
            end
            ACT_DEL: begin
              if (out_free) begin
                cmd_ready_o = 1'b1;
                out_load    = 1'b1;
                valid_we    = cmd_i.slot_ok;
                valid_wa    = cmd_i.slot_idx;
                valid_wd    = 1'b0;
                out_d = mk_rsp(KIND_DEL, cmd_i.slot_field, 8'd0, cmd_i.slot_ok, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end

      // Visit one slot per cycle and age it if it is live
      ST_TICK: begin
        if (valid_q[idx_q]) begin
          slot_we = 1'b1;
          slot_wd.cd = cd_dec;
          if (cd_dec == '0) begin
            slot_wd.pend = pend_inc;
            if (cur.period != '0) begin
              slot_wd.cd = {1'b0, cur.period};
            end
          end
        end
        if (last_idx) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      // Hold each ready slot until the next one shows whether it is the last
      ST_DISP: begin
        if (disp_rdy) begin
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_load = 1'b1;
              out_d = mk_rsp(KIND_TASK, 3'(hold_idx_q), hold_task_q, 1'b1, 1'b0);
            end
            hold_v_d     = 1'b1;
            hold_idx_d   = idx_q;
            hold_task_d  = cur.task_id;
            cnt_d        = cnt_q + CNT_W'(1);
            slot_we      = 1'b1;
            slot_wd.pend = cur.pend - PENDING_BITS'(1);
            if (cur.period == '0) begin
              valid_we = 1'b1;
              valid_wd = 1'b0;
            end
            if (last_idx || (cnt_d == CNT_W'(MAX_OUT))) begin
              state_d = ST_FLUSH;
            end else begin
              idx_d = idx_q + SLOT_W'(1);
            end
          end
        end else if (last_idx) begin
          state_d = ST_FLUSH;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      // Emit the closing result
      ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hold_v_q) begin
            out_d = mk_rsp(KIND_TASK, 3'(hold_idx_q), hold_task_q, 1'b1, 1'b1);
          end else begin
            out_d = mk_rsp(KIND_NONE, 3'd0, 8'd0, 1'b0, 1'b1);
          end
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Load wins over drain on the output register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      tick_step_q <= TICK_STEP_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
      if (valid_we) begin
        valid_q[valid_wa] <= valid_wd;
      end
      if (cfg_we_i) begin
        tick_step_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hold_idx_q  <= hold_idx_d;
    hold_task_q <= hold_task_d;
    out_q       <= out_d;
    if (slot_we) begin
      slot_q[slot_wa] <= slot_wd;
    end
  end

endmodule

/* hdl/cooperative_task_timer_table_core.sv */
// ----------------------------------------------------------------------------
// Cooperative task timer table core
// Eight-slot task timer table with tick, add, delete and dispatch commands.
// ----------------------------------------------------------------------------
// An input item is taken into a two-entry command queue in the cycle it is
// offered, as long as the queue has room, so the request side runs ahead of the
// table. Add and delete finish once they reach the head of the queue and the
// output register is free, and give one result. Tick and dispatch are taken
// without waiting on the output and then walk the table one slot per cycle
// through a single countdown subtractor; a dispatch can stall its walk while
// the output register is busy, and ends with a closing result. Results leave
// through a registered output: add, delete and each dispatch result wait while
// that register still holds an untaken result, and a tick never waits on it.
// No clearing pass runs after reset: the table is usable straight out of reset.
module cooperative_task_timer_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ctt_req_if.sink     req_i,
  ctt_rsp_if.source   rsp_o
);
  import ctt_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Decode incoming items
  ctt_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Decouple front from back
  ctt_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Execute against the slot table
  ctt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

/* hdl/ctt_checker.sv */
// ----------------------------------------------------------------------------
// Timer table checker
// Watches the result port of the timer table core over time.
// ----------------------------------------------------------------------------
`include "cooperative_task_timer_table_core_defines.svh"

module ctt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input ctt_pkg::rsp_t rsp_data_i
);
  import ctt_pkg::*;

  // Hold a stalled result unchanged
  `CTT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "stalled result changed")

  // Close every answer that is not a task at once and carry no task
  `CTT_ASSERT_IMP(a_single_last, clk_i, rst_ni, rsp_valid_i && rsp_data_i.kind != KIND_TASK, rsp_data_i.last && rsp_data_i.run_task == 8'd0, "single answer not closed")

  // Mark every dispatched task as done
  `CTT_ASSERT_IMP(a_task_ok, clk_i, rst_ni, rsp_valid_i && rsp_data_i.kind == KIND_TASK, rsp_data_i.ok, "dispatched task without ok")

  // Follow an open dispatch transfer only with more tasks
  `CTT_ASSERT_NXT(a_disp_cont, clk_i, rst_ni, rsp_valid_i && rsp_ready_i && !rsp_data_i.last, !rsp_valid_i || rsp_data_i.kind == KIND_TASK, "open dispatch interrupted")

  // Leave reset with no result pending
  `CTT_ASSERT_ALL(a_rst_idle, clk_i, $rose(rst_ni), !rsp_valid_i, "result pending after reset")

endmodule

bind cooperative_task_timer_table_core ctt_checker u_ctt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
